// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FLRA_CHECK(lbl, ck, rn, cond, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |-> (expr)) \
        else $error("flra: same-cycle check failed");

// next-cycle implication
`define FLRA_NEXT(lbl, ck, rn, cond, expr) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (cond) |=> (expr)) \
        else $error("flra: next-cycle check failed");

`endif

// ===== hdl/flra_pkg.sv =====
// Shared types and codes for the free-list region allocator.
// No dependencies.
package flra_pkg;

    typedef logic [2:0] cell_cmd_t;

    localparam cell_cmd_t CMD_HOLD    = 3'd0;
    localparam cell_cmd_t CMD_INIT    = 3'd1;
    localparam cell_cmd_t CMD_ROTATE  = 3'd2;
    localparam cell_cmd_t CMD_GRAVITY = 3'd3;
    localparam cell_cmd_t CMD_INSERT  = 3'd4;
    localparam cell_cmd_t CMD_UPDATE  = 3'd5;

    typedef struct packed {
        cell_cmd_t cmd;
        logic      hit;     // this cell is the target entry
        logic      above;   // this cell lies above the target entry
    } cell_ctrl_t;

    typedef logic [2:0] opcode_t;

    localparam opcode_t OP_FIRST = 3'd0;
    localparam opcode_t OP_BEST  = 3'd1;
    localparam opcode_t OP_WORST = 3'd2;
    localparam opcode_t OP_NEXT  = 3'd3;
    localparam opcode_t OP_FREE  = 3'd4;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_NOFIT   = 3'd1;
    localparam status_t ST_OVERLAP = 3'd2;
    localparam status_t ST_BEYOND  = 3'd3;
    localparam status_t ST_FULL    = 3'd4;

endpackage

// ===== hdl/flra_cell.sv =====
// One table cell of the region allocator: holds one free region.
// Depends on flra_pkg.
module flra_cell
    import flra_pkg::*;
#(
    parameter int W = 17
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cell_ctrl_t   ctrl,
    input  logic [W-1:0] wr_s,
    input  logic [W-1:0] wr_l,
    input  logic         left_v,
    input  logic [W-1:0] left_s,
    input  logic [W-1:0] left_l,
    input  logic         right_v,
    input  logic [W-1:0] right_s,
    input  logic [W-1:0] right_l,
    input  logic         hole_in,
    output logic         hole_out,
    output logic         q_v,
    output logic [W-1:0] q_s,
    output logic [W-1:0] q_l
);

    logic         v_reg;
    logic         v_next;
    logic [W-1:0] s_reg;
    logic [W-1:0] s_next;
    logic [W-1:0] l_reg;
    logic [W-1:0] l_next;

    assign hole_out = hole_in || !v_reg;
    assign q_v      = v_reg;
    assign q_s      = s_reg;
    assign q_l      = l_reg;

    always_comb
    begin
        v_next = v_reg;
        s_next = s_reg;
        l_next = l_reg;
        unique case (ctrl.cmd)
            CMD_HOLD:
            begin
            end
            CMD_INIT:
            begin
                v_next = ctrl.hit;
                s_next = ctrl.hit ? wr_s : '0;
                l_next = ctrl.hit ? wr_l : '0;
            end
            CMD_ROTATE:
            begin
                v_next = right_v;
                s_next = right_s;
                l_next = right_l;
            end
            CMD_GRAVITY:
            begin
                // everything from the first hole upward moves down one place
                if (hole_in || !v_reg)
                begin
                    v_next = right_v;
                    s_next = right_s;
                    l_next = right_l;
                end
            end
            CMD_INSERT:
            begin
                if (ctrl.hit)
                begin
                    v_next = 1'b1;
                    s_next = wr_s;
                    l_next = wr_l;
                end
                else if (ctrl.above)
                begin
                    v_next = left_v;
                    s_next = left_s;
                    l_next = left_l;
                end
            end
            CMD_UPDATE:
            begin
                if (ctrl.hit)
                begin
                    s_next = s_reg + wr_l;
                    l_next = l_reg - wr_l;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        l_reg <= l_next;
    end

endmodule

// ===== hdl/free_list_region_allocator.sv =====
// Free-list region allocator. The free table lives in a ring of MAX_REGIONS cells that
// rotates past one head cell, which the controller reads and refills at the tail. An
// allocation passes from accept to result through a merge rotation, a compaction sweep,
// a selection rotation, an update step and an output step. A free skips the merge and
// compaction sweep; free requests of length zero or beyond memory, and unused opcodes,
// go straight to the output step. One request is in flight at a time; the next is taken
// while the previous result waits at the output. After reset the table is loaded in the
// boot state; a write of mem_size reloads it.
// Depends on flra_pkg and flra_cell.
module free_list_region_allocator
    import flra_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int ADDR_BITS   = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [ADDR_BITS:0]   mem_size,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           opcode,
    input  logic [ADDR_BITS:0]   amount,
    input  logic [ADDR_BITS-1:0] free_start,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 ok,
    output logic [2:0]           status,
    output logic [ADDR_BITS-1:0] alloc_addr
);

    localparam int RW = ADDR_BITS + 1;
    localparam int EW = ADDR_BITS + 2;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int NW = $clog2(MAX_REGIONS);
    localparam logic [CW-1:0] LAST = CW'(MAX_REGIONS - 1);
    localparam logic [CW-1:0] NREG = CW'(MAX_REGIONS);
    localparam logic [RW-1:0] SPAN = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic [2:0] S_BOOT    = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_MERGE   = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_APPLY   = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    logic [2:0]           state_reg, state_next;
    opcode_t              op_reg, op_next;
    logic [RW-1:0]        amt_reg, amt_next;
    logic [ADDR_BITS-1:0] fs_reg, fs_next;
    logic [RW-1:0]        msize_reg, msize_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [NW-1:0]        nf_reg, nf_next;
    logic                 nf_valid_reg, nf_valid_next;
    logic [CW-1:0]        step_reg, step_next;
    logic                 acc_v_reg, acc_v_next;
    logic [RW-1:0]        acc_s_reg, acc_s_next;
    logic [RW-1:0]        acc_l_reg, acc_l_next;
    logic [CW-1:0]        wcnt_reg, wcnt_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        pick_reg, pick_next;
    logic [RW-1:0]        pick_s_reg, pick_s_next;
    logic [RW-1:0]        pick_l_reg, pick_l_next;
    logic                 found_ge_reg, found_ge_next;
    logic [CW-1:0]        ge_reg, ge_next;
    logic [RW-1:0]        ge_s_reg, ge_s_next;
    logic                 ov_reg, ov_next;
    logic [CW-1:0]        pos_reg, pos_next;
    logic                 res_ok_reg, res_ok_next;
    status_t              res_st_reg, res_st_next;
    logic [ADDR_BITS-1:0] res_addr_reg, res_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_ok_reg, out_ok_next;
    status_t              out_st_reg, out_st_next;
    logic [ADDR_BITS-1:0] out_addr_reg, out_addr_next;

    cell_cmd_t            cmd;
    logic [CW-1:0]        tgt;
    logic [RW-1:0]        wr_s, wr_l;
    logic                 tail_v;
    logic [RW-1:0]        tail_s, tail_l;

    logic                 q_v [MAX_REGIONS];
    logic [RW-1:0]        q_s [MAX_REGIONS];
    logic [RW-1:0]        q_l [MAX_REGIONS];
    logic                 hole [MAX_REGIONS+1];

    logic                 head_v;
    logic [RW-1:0]        head_s, head_l;
    logic [RW-1:0]        ms_sat;
    logic [EW-1:0]        fend;
    logic                 merge_hit;
    logic                 fits;
    logic [CW-1:0]        scan_from;
    logic                 ovl;
    logic                 in_acc;
    logic                 nf_ok;

    assign head_v = q_v[0];
    assign head_s = q_s[0];
    assign head_l = q_l[0];

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign in_acc    = in_valid && in_ready;

    assign out_valid  = out_valid_reg;
    assign ok         = out_ok_reg;
    assign status     = out_st_reg;
    assign alloc_addr = out_addr_reg;

    always_comb
    begin
        if (mem_size == '0)
        begin
            ms_sat = RW'(1);
        end
        else if (mem_size[ADDR_BITS] && (mem_size[ADDR_BITS-1:0] != '0))
        begin
            ms_sat = SPAN;
        end
        else
        begin
            ms_sat = mem_size;
        end
    end

    assign fend      = EW'(fs_reg) + EW'(amt_reg);
    assign merge_hit = head_v && acc_v_reg
                       && (EW'(acc_s_reg) + EW'(acc_l_reg) == EW'(head_s));
    assign fits      = head_v && (head_l >= amt_reg);
    assign nf_ok     = nf_valid_reg && (CW'(nf_reg) < count_reg);
    assign scan_from = nf_ok ? CW'(nf_reg) : '0;
    assign ovl       = head_v && (EW'(head_s) < fend)
                       && ((head_s > RW'(fs_reg))
                           || (EW'(head_s) + EW'(head_l) > EW'(fs_reg)));

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        amt_next       = amt_reg;
        fs_next        = fs_reg;
        msize_next     = msize_reg;
        count_next     = count_reg;
        nf_next        = nf_reg;
        nf_valid_next  = nf_valid_reg;
        step_next      = step_reg;
        acc_v_next     = acc_v_reg;
        acc_s_next     = acc_s_reg;
        acc_l_next     = acc_l_reg;
        wcnt_next      = wcnt_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_s_next    = pick_s_reg;
        pick_l_next    = pick_l_reg;
        found_ge_next  = found_ge_reg;
        ge_next        = ge_reg;
        ge_s_next      = ge_s_reg;
        ov_next        = ov_reg;
        pos_next       = pos_reg;
        res_ok_next    = res_ok_reg;
        res_st_next    = res_st_reg;
        res_addr_next  = res_addr_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_st_next    = out_st_reg;
        out_addr_next  = out_addr_reg;

        cmd    = CMD_HOLD;
        tgt    = '0;
        wr_s   = '0;
        wr_l   = '0;
        tail_v = head_v;
        tail_s = head_s;
        tail_l = head_l;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_BOOT:
            begin
                cmd        = CMD_INIT;
                wr_l       = msize_reg;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    msize_next    = ms_sat;
                    count_next    = CW'(1);
                    nf_valid_next = 1'b0;
                    cmd           = CMD_INIT;
                    wr_l          = ms_sat;
                end
                else if (in_acc)
                begin
                    op_next       = opcode;
                    amt_next      = amount;
                    fs_next       = free_start;
                    acc_v_next    = 1'b0;
                    wcnt_next     = '0;
                    step_next     = '0;
                    found_next    = 1'b0;
                    found_ge_next = 1'b0;
                    ov_next       = 1'b0;
                    pos_next      = '0;
                    res_ok_next   = 1'b0;
                    res_addr_next = '0;
                    if (opcode > OP_FREE)
                    begin
                        res_st_next = ST_NOFIT;
                        state_next  = S_DONE;
                    end
                    else if (opcode == OP_FREE)
                    begin
                        if (amount == '0)
                        begin
                            res_ok_next = 1'b1;
                            res_st_next = ST_OK;
                            state_next  = S_DONE;
                        end
                        else if (EW'(free_start) + EW'(amount) > EW'(msize_reg))
                        begin
                            res_st_next = ST_BEYOND;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    else
                    begin
                        nf_valid_next = nf_ok;
                        state_next    = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                // controller accumulator acts as the extra ring slot
                cmd = CMD_ROTATE;
                if (merge_hit)
                begin
                    tail_v     = 1'b0;
                    acc_l_next = acc_l_reg + head_l;
                end
                else
                begin
                    tail_v     = acc_v_reg;
                    tail_s     = acc_s_reg;
                    tail_l     = acc_l_reg;
                    acc_v_next = head_v;
                    acc_s_next = head_s;
                    acc_l_next = head_l;
                    if (acc_v_reg)
                    begin
                        wcnt_next = wcnt_reg + CW'(1);
                    end
                end
                if (head_v && nf_valid_reg && (step_reg == CW'(nf_reg)))
                begin
                    nf_next = wcnt_next[NW-1:0];
                end
                if (step_reg == NREG)
                begin
                    count_next = wcnt_next;
                    step_next  = '0;
                    state_next = S_COMPACT;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            S_COMPACT:
            begin
                cmd    = CMD_GRAVITY;
                tail_v = 1'b0;
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            S_SCAN:
            begin
                cmd = CMD_ROTATE;
                if (op_reg == OP_FREE)
                begin
                    if (ovl)
                    begin
                        ov_next = 1'b1;
                    end
                    if (head_v && (head_s <= RW'(fs_reg)))
                    begin
                        pos_next = step_reg + CW'(1);
                    end
                end
                else if (op_reg == OP_NEXT)
                begin
                    if (fits && !found_reg)
                    begin
                        found_next  = 1'b1;
                        pick_next   = step_reg;
                        pick_s_next = head_s;
                    end
                    if (fits && !found_ge_reg && (step_reg >= scan_from))
                    begin
                        found_ge_next = 1'b1;
                        ge_next       = step_reg;
                        ge_s_next     = head_s;
                    end
                end
                else
                begin
                    if (fits && (!found_reg
                                 || ((op_reg == OP_BEST) && (head_l < pick_l_reg))
                                 || ((op_reg == OP_WORST) && (head_l > pick_l_reg))))
                    begin
                        found_next  = 1'b1;
                        pick_next   = step_reg;
                        pick_s_next = head_s;
                        pick_l_next = head_l;
                    end
                end
                if (step_reg == LAST)
                begin
                    step_next  = '0;
                    state_next = S_APPLY;
                end
                else
                begin
                    step_next = step_reg + CW'(1);
                end
            end
            S_APPLY:
            begin
                state_next    = S_DONE;
                res_addr_next = '0;
                if (op_reg == OP_FREE)
                begin
                    res_ok_next = 1'b0;
                    if (ov_reg)
                    begin
                        res_st_next = ST_OVERLAP;
                    end
                    else if (count_reg >= NREG)
                    begin
                        res_st_next = ST_FULL;
                    end
                    else
                    begin
                        cmd         = CMD_INSERT;
                        tgt         = pos_reg;
                        wr_s        = RW'(fs_reg);
                        wr_l        = amt_reg;
                        count_next  = count_reg + CW'(1);
                        res_ok_next = 1'b1;
                        res_st_next = ST_OK;
                        if (nf_valid_reg && (CW'(nf_reg) >= pos_reg))
                        begin
                            nf_next = nf_reg + NW'(1);
                        end
                    end
                end
                else if (found_reg)
                begin
                    cmd         = CMD_UPDATE;
                    wr_l        = amt_reg;
                    res_ok_next = 1'b1;
                    res_st_next = ST_OK;
                    if ((op_reg == OP_NEXT) && found_ge_reg)
                    begin
                        tgt           = ge_reg;
                        res_addr_next = ge_s_reg[ADDR_BITS-1:0];
                    end
                    else
                    begin
                        tgt           = pick_reg;
                        res_addr_next = pick_s_reg[ADDR_BITS-1:0];
                    end
                    if (op_reg == OP_NEXT)
                    begin
                        nf_next       = tgt[NW-1:0];
                        nf_valid_next = 1'b1;
                    end
                end
                else
                begin
                    res_ok_next = 1'b0;
                    res_st_next = ST_NOFIT;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_st_next    = res_st_reg;
                    out_addr_next  = res_addr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            msize_reg     <= SPAN;
            count_reg     <= CW'(1);
            nf_valid_reg  <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msize_reg     <= msize_next;
            count_reg     <= count_next;
            nf_valid_reg  <= nf_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        amt_reg      <= amt_next;
        fs_reg       <= fs_next;
        nf_reg       <= nf_next;
        acc_v_reg    <= acc_v_next;
        acc_s_reg    <= acc_s_next;
        acc_l_reg    <= acc_l_next;
        wcnt_reg     <= wcnt_next;
        found_reg    <= found_next;
        pick_reg     <= pick_next;
        pick_s_reg   <= pick_s_next;
        pick_l_reg   <= pick_l_next;
        found_ge_reg <= found_ge_next;
        ge_reg       <= ge_next;
        ge_s_reg     <= ge_s_next;
        ov_reg       <= ov_next;
        pos_reg      <= pos_next;
        res_ok_reg   <= res_ok_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        out_ok_reg   <= out_ok_next;
        out_st_reg   <= out_st_next;
        out_addr_reg <= out_addr_next;
    end

    assign hole[0] = 1'b0;

    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        cell_ctrl_t    ctrl;
        logic          lv;
        logic [RW-1:0] ls, ll;
        logic          rv;
        logic [RW-1:0] rs, rl;

        assign ctrl.cmd   = cmd;
        assign ctrl.hit   = (tgt == CW'(i));
        assign ctrl.above = (CW'(i) > tgt);

        if (i == 0)
        begin : g_first
            assign lv = 1'b0;
            assign ls = '0;
            assign ll = '0;
        end
        else
        begin : g_mid
            assign lv = q_v[i-1];
            assign ls = q_s[i-1];
            assign ll = q_l[i-1];
        end

        if (i == MAX_REGIONS - 1)
        begin : g_tail
            assign rv = tail_v;
            assign rs = tail_s;
            assign rl = tail_l;
        end
        else
        begin : g_body
            assign rv = q_v[i+1];
            assign rs = q_s[i+1];
            assign rl = q_l[i+1];
        end

        flra_cell #(
            .W (RW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .wr_s     (wr_s),
            .wr_l     (wr_l),
            .left_v   (lv),
            .left_s   (ls),
            .left_l   (ll),
            .right_v  (rv),
            .right_s  (rs),
            .right_l  (rl),
            .hole_in  (hole[i]),
            .hole_out (hole[i+1]),
            .q_v      (q_v[i]),
            .q_s      (q_s[i]),
            .q_l      (q_l[i])
        );
    end

endmodule

// ===== hdl/flra_checker.sv =====
// Port-level checker for the free-list region allocator, bound to the top level.
// Depends on flra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flra_checker
    import flra_pkg::*;
#(
    parameter int ADDR_BITS = 16
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 ok,
    input logic [2:0]           status,
    input logic [ADDR_BITS-1:0] alloc_addr
);

    `FLRA_CHECK(a_ok_matches_status, clk, rst_n, out_valid, ok == (status == ST_OK))
    `FLRA_CHECK(a_fail_has_no_addr, clk, rst_n, out_valid && !ok, alloc_addr == '0)
    // one request in flight: no word taken right after another
    `FLRA_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)
    `FLRA_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(alloc_addr))

endmodule

bind free_list_region_allocator flra_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_flra_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .status     (status),
    .alloc_addr (alloc_addr)
);
